// ===== rtl/bph_pkg.sv =====
package bph_pkg;

    localparam int unsigned ALPHABET_SIZE = 256;
    localparam int unsigned COUNT_WIDTH   = 32;

    localparam int unsigned SYM_W        = 8;
    localparam int unsigned PAIR_COUNT_W = 32;
    localparam int unsigned TABLE_DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int unsigned ADDR_W       = $clog2(TABLE_DEPTH);

    typedef logic [SYM_W-1:0]       sym_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    // write request into the counter table
    typedef struct packed {
        logic   en;
        addr_t  addr;
        count_t data;
    } wr_req_t;

    function automatic logic in_alphabet(input sym_t v);
        return (32'(v) < ALPHABET_SIZE);
    endfunction

    function automatic addr_t pair_addr(input sym_t row, input sym_t col);
        return ADDR_W'(32'(row) * ALPHABET_SIZE + 32'(col));
    endfunction

endpackage

// ===== rtl/bph_pair_table.sv =====
module bph_pair_table
    import bph_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    rd_en,
    input  addr_t   rd_addr,
    output count_t  rd_data,
    input  wr_req_t wr,
    output logic    clear_done
);

    count_t mem [TABLE_DEPTH];
    count_t rd_data_reg;
    addr_t  clr_addr_reg;
    logic   clear_done_reg;

    logic   we;
    addr_t  wa;
    count_t wd;

    // sweep zeros through the table after reset, then take pipeline writes
    always_comb begin
        if (!clear_done_reg) begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end else begin
            we = wr.en;
            wa = wr.addr;
            wd = wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            clear_done_reg <= 1'b0;
        end else if (!clear_done_reg) begin
            if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                clear_done_reg <= 1'b1;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_done = clear_done_reg;

endmodule

// ===== rtl/byte_pair_histogram.sv =====
// Byte pair histogram: counts every pair of consecutive bytes of a stream in a
// table of saturating counters indexed by (earlier byte, later byte).
//
// Input channel (s_): one transaction per command. s_tuser[0] selects push
// (store a data byte, count the pair it closes) or read (return one counter).
// A push flagged start_of_file opens a new file and closes no pair.
// Result channel (m_): one transaction per read, none per push, in order.
//
// Throughput: one transaction per cycle while no read waits on m_tready. The
// table sits in one synchronous memory with a read port and a write port; the
// read is issued at acceptance, the incremented count is written in the next
// cycle, and a one-deep forwarding register covers a write that the next read
// has not yet seen. A read's result passes stage 1 and the result register.
//
// Reset: a clearing pass writes zero to every counter, one per cycle, over all
// TABLE_DEPTH entries (65536 at the default alphabet); s_tready stays low
// throughout. The previous byte is forgotten, so the first push forms no pair.
// Stall: the result register holds while m_tready is low; pushes keep flowing
// until a read reaches it and must wait, then s_tready drops.
module byte_pair_histogram
    import bph_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: byte_value[7:0], start_of_file[8], read_row[16:9], read_col[24:17]
    input  logic [31:0] s_tdata,
    // s_tuser: command[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: pair_count[31:0], row_echo[39:32], col_echo[47:40]
    output logic [47:0] m_tdata
);

    typedef enum logic {
        KIND_BUMP,
        KIND_READ
    } kind_t;

    // unpack the input transaction
    cmd_t cmd;
    sym_t in_byte;
    logic in_sof;
    sym_t in_row;
    sym_t in_col;

    assign cmd     = cmd_t'(s_tuser[0]);
    assign in_byte = s_tdata[7:0];
    assign in_sof  = s_tdata[8];
    assign in_row  = s_tdata[16:9];
    assign in_col  = s_tdata[24:17];

    // chain state
    sym_t prev_byte_reg;
    logic have_prev_reg;

    // stage 1: memory data is back, modify and write
    logic   s1_valid_reg;
    kind_t  s1_kind_reg;
    logic   s1_zero_reg;
    addr_t  s1_addr_reg;
    sym_t   s1_row_reg;
    sym_t   s1_col_reg;

    // last write, for forwarding
    logic   fwd_valid_reg;
    addr_t  fwd_addr_reg;
    count_t fwd_data_reg;

    // result register
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    logic    clear_done;
    logic    accept;
    logic    do_bump;
    logic    do_read;
    logic    s1_hold;
    logic    rd_en;
    addr_t   rd_addr;
    count_t  rd_data;
    count_t  cur;
    wr_req_t wr;
    logic [63:0] cur_wide;
    logic [PAIR_COUNT_W-1:0] pair_out;

    // a read waiting on a full result register blocks the pipe
    assign s1_hold  = s1_valid_reg && (s1_kind_reg == KIND_READ) && m_tvalid_reg && !m_tready;
    assign s_tready = clear_done && !s1_hold;
    assign accept   = s_tvalid && s_tready;

    assign do_bump = (cmd == CMD_PUSH) && in_alphabet(in_byte) && have_prev_reg && !in_sof;
    assign do_read = (cmd == CMD_READ);

    assign rd_en   = accept && (do_bump || do_read);
    assign rd_addr = do_read ? pair_addr(in_row, in_col) : pair_addr(prev_byte_reg, in_byte);

    bph_pair_table u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr         (wr),
        .clear_done (clear_done)
    );

    // take the last write if memory has not caught up with it
    assign cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;

    always_comb begin
        wr.en   = s1_valid_reg && (s1_kind_reg == KIND_BUMP);
        wr.addr = s1_addr_reg;
        wr.data = (cur == '1) ? cur : cur + 1'b1;   // saturate, do not wrap
    end

    // clamp the counter to the result width, or zero it outside the alphabet
    assign cur_wide = 64'(cur);
    assign pair_out = s1_zero_reg ? '0 :
                      (cur_wide > 64'({PAIR_COUNT_W{1'b1}})) ? '1 :
                      cur_wide[PAIR_COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_byte_reg <= '0;
            have_prev_reg <= 1'b0;
        end else if (accept && (cmd == CMD_PUSH)) begin
            if (in_alphabet(in_byte)) begin
                prev_byte_reg <= in_byte;
                have_prev_reg <= 1'b1;
            end else begin
                have_prev_reg <= 1'b0;   // break the chain
            end
        end
    end

    // stage 1 and forwarding control; advance only when not held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else if (!s1_hold) begin
            s1_valid_reg  <= accept && (do_bump || do_read);
            fwd_valid_reg <= wr.en;
        end
    end

    always_ff @(posedge aclk) begin
        if (!s1_hold) begin
            s1_kind_reg  <= do_read ? KIND_READ : KIND_BUMP;
            s1_zero_reg  <= !(in_alphabet(in_row) && in_alphabet(in_col));
            s1_addr_reg  <= rd_addr;
            s1_row_reg   <= in_row;
            s1_col_reg   <= in_col;
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
    end

    // result register: load a finished read, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_valid_reg && (s1_kind_reg == KIND_READ) && !s1_hold) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && (s1_kind_reg == KIND_READ) && !s1_hold) begin
            m_tdata_reg <= {s1_col_reg, s1_row_reg, pair_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/bph_checker.sv =====
module bph_checker
    import bph_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // the clearing pass keeps the input closed right after reset
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready during table clear");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // an accepted read is followed by a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == CMD_READ)) |-> ##2 m_tvalid)
        else $error("read produced no result");

    // a result only ever follows an accepted read
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser[0] == CMD_READ), 2))
        else $error("result without a read");

endmodule

bind byte_pair_histogram bph_checker u_bph_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_byte_pair_histogram.sv =====
module tb_byte_pair_histogram;
    import bph_pkg::*;

    // Budget: the clearing pass after reset plus about 525 transactions, each at
    // worst a long sender gap and a long receiver stall, taken many times over.
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned PHASE_ITEMS  = 167;
    localparam int unsigned SETTLE_TICKS = 20;
    localparam int unsigned SCRIPT_LEN   = 23;

    // one input transaction, as the fields of the work item
    typedef struct packed {
        cmd_t  cmd;
        sym_t  sym;
        logic  sof;
        sym_t  row;
        sym_t  col;
    } hist_cmd_t;

    // one row of the directed script; a typed count replaces the prediction
    typedef struct packed {
        hist_cmd_t   op;
        logic        typed;
        logic [31:0] want;
    } script_row_t;

    typedef struct {
        logic [31:0] count;
        sym_t        row;
        sym_t        col;
    } read_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    byte_pair_histogram dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the counter table and the pair chain.
    bit [COUNT_WIDTH-1:0] tally [TABLE_DEPTH];
    sym_t                 prev_sym  = '0;
    bit                   prev_held = 1'b0;

    // Reads accepted but not yet answered, oldest first.
    read_result_t awaited_reads[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned n_push        = 0;
    int unsigned n_read        = 0;
    int unsigned n_sof         = 0;
    int unsigned n_checked     = 0;

    // Generator state: the symbols that recur in a phase, and the last pair formed.
    sym_t hot [6];
    sym_t gen_prev = '0;
    sym_t gen_cur  = '0;

    // Count the pair that a pushed byte closes, saturating at the counter maximum.
    function automatic void tally_push(input sym_t sym, input logic sof);
        int unsigned slot;
        if (32'(sym) >= ALPHABET_SIZE) begin
            // a byte outside the alphabet breaks the chain
            prev_held = 1'b0;
            return;
        end
        if (prev_held && !sof) begin
            slot = 32'(prev_sym) * ALPHABET_SIZE + 32'(sym);
            if (tally[slot] != '1)
                tally[slot] = tally[slot] + 1'b1;
        end
        prev_sym  = sym;
        prev_held = 1'b1;
    endfunction

    // Look up one counter as the result channel reports it: zero outside the
    // alphabet, clipped to 32 bits for wide counters.
    function automatic logic [31:0] tally_lookup(input sym_t row, input sym_t col);
        logic [63:0] wide;
        wide = '0;
        if (32'(row) < ALPHABET_SIZE && 32'(col) < ALPHABET_SIZE)
            wide = 64'(tally[32'(row) * ALPHABET_SIZE + 32'(col)]);
        if (wide > 64'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return wide[31:0];
    endfunction

    // Offer one transaction at the falling edge, hold it until the block
    // takes it, then advance the shadow state. Returns at a falling edge with
    // s_tvalid still high, so a back-to-back transaction needs no second
    // assignment in the same step.
    task automatic send_cmd(input hist_cmd_t op, input logic typed, input logic [31:0] want);
        read_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, op.col, op.row, op.sof, op.sym};
        s_tuser  <= op.cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (op.cmd == CMD_PUSH) begin
            tally_push(op.sym, op.sof);
            n_push++;
            if (op.sof)
                n_sof++;
        end else begin
            res.count = typed ? want : tally_lookup(op.row, op.col);
            res.row   = op.row;
            res.col   = op.col;
            awaited_reads.push_back(res);
            n_read++;
        end
        @(negedge aclk);
    endtask

    // Drop s_tvalid and hold off until every awaited read has come back.
    task automatic drain_reads();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (awaited_reads.size() != 0)
            @(negedge aclk);
    endtask

    // Mostly bytes from the phase's recurring set, with repeats to hammer
    // one counter on consecutive cycles; reads mostly target pairs of recurring symbols.
    // Fields that the command ignores carry random noise.
    function automatic hist_cmd_t random_cmd();
        hist_cmd_t op;
        int unsigned pick;
        op.sym = sym_t'($urandom);
        op.sof = 1'($urandom);
        op.row = sym_t'($urandom);
        op.col = sym_t'($urandom);
        if ($urandom_range(99) < 65) begin
            op.cmd = CMD_PUSH;
            pick = $urandom_range(99);
            if (pick < 20)
                op.sym = gen_cur;
            else if (pick < 80)
                op.sym = hot[$urandom_range(5)];
            op.sof = ($urandom_range(99) < 6);
            if (!op.sof) begin
                gen_prev = gen_cur;
            end
            gen_cur = op.sym;
        end else begin
            op.cmd = CMD_READ;
            pick = $urandom_range(99);
            if (pick < 70) begin
                op.row = hot[$urandom_range(5)];
                op.col = hot[$urandom_range(5)];
            end else if (pick < 85) begin
                op.row = gen_prev;
                op.col = gen_cur;
            end
        end
        return op;
    endfunction

    // Directed script: reads of a cleared table, the extreme bytes, the first
    // byte after reset, start of file, a read between two pushes of a pair and
    // one-byte files. Counts typed in are plain to see; the rest are predicted.
    script_row_t script [SCRIPT_LEN] = '{
        '{'{CMD_READ, 8'hFF, 1'b1, 8'h00, 8'h00}, 1'b1, 32'd0},
        '{'{CMD_READ, 8'h00, 1'b0, 8'hFF, 8'hFF}, 1'b1, 32'd0},
        '{'{CMD_READ, 8'hFF, 1'b0, 8'h00, 8'hFF}, 1'b1, 32'd0},
        '{'{CMD_PUSH, 8'h00, 1'b0, 8'hFF, 8'hFF}, 1'b0, 32'd0},
        '{'{CMD_PUSH, 8'h00, 1'b0, 8'h00, 8'h00}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'h00, 1'b0, 8'h00, 8'h00}, 1'b1, 32'd1},
        '{'{CMD_PUSH, 8'hFF, 1'b0, 8'h00, 8'h00}, 1'b0, 32'd0},
        '{'{CMD_PUSH, 8'hFF, 1'b0, 8'hFF, 8'hFF}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'h00, 1'b1, 8'hFF, 8'hFF}, 1'b1, 32'd1},
        '{'{CMD_PUSH, 8'h00, 1'b1, 8'h00, 8'h00}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'h00, 1'b0, 8'hFF, 8'h00}, 1'b1, 32'd0},
        '{'{CMD_PUSH, 8'hFF, 1'b0, 8'h00, 8'h00}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'hFF, 1'b1, 8'h00, 8'hFF}, 1'b1, 32'd2},
        '{'{CMD_PUSH, 8'hA5, 1'b1, 8'h5A, 8'hA5}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'h5A, 1'b0, 8'hA5, 8'h5A}, 1'b1, 32'd0},
        '{'{CMD_PUSH, 8'h5A, 1'b0, 8'h00, 8'h00}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'h00, 1'b0, 8'hA5, 8'h5A}, 1'b0, 32'd0},
        '{'{CMD_PUSH, 8'h3C, 1'b1, 8'h00, 8'h00}, 1'b0, 32'd0},
        '{'{CMD_PUSH, 8'hC3, 1'b1, 8'h00, 8'h00}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'h00, 1'b0, 8'h3C, 8'hC3}, 1'b0, 32'd0},
        '{'{CMD_PUSH, 8'hC3, 1'b0, 8'h00, 8'h00}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'h00, 1'b0, 8'hC3, 8'hC3}, 1'b0, 32'd0},
        '{'{CMD_READ, 8'hFF, 1'b1, 8'h00, 8'hFF}, 1'b0, 32'd0}
    };

    // Receiver: decide readiness at every falling edge.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Check every result transaction against the oldest awaited read.
    always @(posedge aclk) begin
        read_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_reads.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual count %0d row %0d col %0d",
                         $time, m_tdata[31:0], m_tdata[39:32], m_tdata[47:40]);
                error_count++;
            end else begin
                want = awaited_reads.pop_front();
                n_checked++;
                if (m_tdata[31:0] !== want.count) begin
                    $display("%0t: pair_count mismatch: expected %0d actual %0d",
                             $time, want.count, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[39:32] !== want.row) begin
                    $display("%0t: row_echo mismatch: expected %0d actual %0d",
                             $time, want.row, m_tdata[39:32]);
                    error_count++;
                end
                if (m_tdata[47:40] !== want.col) begin
                    $display("%0t: col_echo mismatch: expected %0d actual %0d",
                             $time, want.col, m_tdata[47:40]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it overstays its cycle budget.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d reads outstanding",
                 $time, awaited_reads.size());
        $display("** byte_pair_histogram: FAILED **");
        $finish;
    end

    initial begin
        // hold reset, then release it at a falling edge
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Phase 1: the sender idles often, the receiver nearly always.
        // The directed script runs here; s_tready stays low through the
        // clearing pass, which send_cmd simply waits out.
        send_idle_pct = 38;
        recv_idle_pct = 88;
        foreach (script[i])
            send_cmd(script[i].op, script[i].typed, script[i].want);
        drain_reads();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 38;
                end
                default: begin
                    // full rate both ways: stress the forwarding path
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // keep the extremes in the recurring set, refresh the rest
            hot[0] = 8'h00;
            hot[1] = 8'hFF;
            for (int k = 2; k < 6; k++)
                hot[k] = sym_t'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // pause midway until the pipeline has emptied
                if (n == PHASE_ITEMS / 2)
                    drain_reads();
                send_cmd(random_cmd(), 1'b0, 32'd0);
            end
            drain_reads();
        end

        // let any stray result surface before the verdict
        repeat (SETTLE_TICKS) @(negedge aclk);
        if (awaited_reads.size() != 0) begin
            $display("%0t: %0d reads never answered", $time, awaited_reads.size());
            error_count++;
        end

        $display("Run covered %0d pushes (%0d file starts) and %0d reads, %0d results checked,",
                 n_push, n_sof, n_read, n_checked);
        $display("under sender-heavy, receiver-heavy and gap-free handshaking; %0d errors.",
                 error_count);
        if (error_count == 0)
            $display("** byte_pair_histogram: PASSED **");
        else
            $display("** byte_pair_histogram: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bph_pkg.sv
rtl/bph_pair_table.sv
rtl/byte_pair_histogram.sv
rtl/bph_checker.sv
tb/tb_byte_pair_histogram.sv
